// ----- rtl/h3d_pkg.sv -----
// Shared constants, widths and digit helpers for the 3D curve index decoder.
package h3d_pkg;

   localparam int H3D_MAX_ORDER = 10;
   localparam int IDX_W = 30;
   localparam int COORD_W = 10;
   localparam int ORDER_W = 4;
   localparam int DIGITS_PER_STAGE = 2;

   localparam logic [23:0] ROT_TABLE = 24'h641289;

   function automatic logic [2:0] rotl3(input logic [2:0] a, input logic [1:0] r);
      logic [2:0] res;
      case (r)
         2'd1: res = {a[1:0], a[2]};
         2'd2: res = {a[0], a[2:1]};
         default: res = a;
      endcase
      return res;
   endfunction

   function automatic logic [1:0] next_rot(input logic [2:0] a, input logic [1:0] r);
      logic [4:0] off;
      off = {r, a[1:0], 1'b0};
      return ROT_TABLE[off +: 2];
   endfunction

endpackage

// ----- rtl/hilbert_3d_index_decode.sv -----
// Top level of the 3D curve index decoder: turns a curve position into x, y, z.
//
// A request is taken on every rising clock edge at which start is high; busy
// never rises, so one request can be accepted in every cycle.
// The request carries req_curve_index. Each request gives exactly one result,
// shown on rsp_point_x, rsp_point_y and rsp_point_z for one cycle while
// rsp_strobe is high. The receiver cannot stall the block.
// The input stage masks the index and applies the Gray-like transform; each
// following stage resolves two curve digits through the rotation recurrence
// and the running prefix XOR.
// Throughput is one request per cycle.
// The order register is written through csr_wr_en and csr_wr_data, and should
// change only while no request is in flight. Reset clears all stage valid bits
// and sets the order to 10, clamped to MAX_ORDER.
module hilbert_3d_index_decode
   import h3d_pkg::*;
#(
   parameter int MAX_ORDER = H3D_MAX_ORDER
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data,
   input  logic               start,
   output logic               busy,
   input  logic [IDX_W-1:0]   req_curve_index,
   output logic               rsp_strobe,
   output logic [COORD_W-1:0] rsp_point_x,
   output logic [COORD_W-1:0] rsp_point_y,
   output logic [COORD_W-1:0] rsp_point_z
);

   localparam int WW = 3 * MAX_ORDER;
   localparam int NS = (MAX_ORDER + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
   localparam int MW = $clog2(MAX_ORDER + 1);
   localparam int TW = $clog2(3 * MAX_ORDER + 1);

   logic [ORDER_W-1:0] order_ff;

   logic [NS:0]   valid_ff, valid_in;
   logic [WW-1:0] word_ff  [0:NS];
   logic [WW-1:0] word_in  [0:NS];
   logic [1:0]    rot_ff   [0:NS];
   logic [1:0]    rot_in   [0:NS];
   logic [2:0]    amask_ff [0:NS];
   logic [2:0]    amask_in [0:NS];
   logic [2:0]    acc_ff   [0:NS];
   logic [2:0]    acc_in   [0:NS];
   logic [MW-1:0] m_ff     [0:NS];
   logic [MW-1:0] m_in     [0:NS];

   logic [ORDER_W+MW-1:0] ord_ext;
   logic [MW-1:0]         m_eff;
   logic [TW-1:0]         total;
   logic [IDX_W+WW-1:0]   idx_ext;
   logic [WW-1:0]         idx_w, idx_mask, gray_mask, gray_pat, idx_v;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(10);
      end else if (csr_wr_en) begin
         order_ff <= csr_wr_data;
      end
   end

   // Input stage: clamp the order, mask the index and apply the Gray-like step.
   always_comb begin
      int j;
      logic [2:0] a, rd, c;
      logic [1:0] r;
      ord_ext = {{MW{1'b0}}, order_ff};
      if (ord_ext > (ORDER_W + MW)'(MAX_ORDER)) begin
         m_eff = MW'(MAX_ORDER);
      end else begin
         m_eff = MW'(ord_ext);
      end
      if (m_eff == '0) begin
         m_eff = MW'(1);
      end
      total = TW'(m_eff) * TW'(3);
      idx_ext = {{WW{1'b0}}, req_curve_index};
      idx_w = idx_ext[WW-1:0];
      gray_pat = '0;
      for (int b = 0; b < WW; b += 3) begin
         gray_pat[b] = 1'b1;
      end
      for (int b = 0; b < WW; b++) begin
         idx_mask[b] = (b < int'(total));
         gray_mask[b] = ((b + 2) < int'(total));
      end
      idx_v = idx_w & idx_mask;
      word_in[0] = idx_v ^ ((idx_v ^ (gray_pat & gray_mask)) >> 1);
      rot_in[0] = '0;
      amask_in[0] = '0;
      acc_in[0] = '0;
      m_in[0] = m_eff;
      valid_in[0] = start;

      // Digit stages: each resolves its digits from the most significant down.
      for (int k = 0; k < NS; k++) begin
         word_in[k+1] = word_ff[k];
         rot_in[k+1] = rot_ff[k];
         amask_in[k+1] = amask_ff[k];
         acc_in[k+1] = acc_ff[k];
         m_in[k+1] = m_ff[k];
         valid_in[k+1] = valid_ff[k];
         for (int t = 0; t < DIGITS_PER_STAGE; t++) begin
            j = MAX_ORDER - 1 - k * DIGITS_PER_STAGE - t;
            a = '0;
            rd = '0;
            c = '0;
            r = '0;
            if (j >= 0 && j < int'(m_ff[k])) begin
               a = word_in[k+1][3*j +: 3];
               r = (rot_in[k+1] == 2'd3) ? 2'd2 : rot_in[k+1];
               rd = rotl3(a, r);
               c = amask_in[k+1] ^ rd;
               acc_in[k+1] = acc_in[k+1] ^ c;
               word_in[k+1][3*j +: 3] = acc_in[k+1];
               amask_in[k+1] = 3'b001 << r;
               rot_in[k+1] = next_rot(a, r);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k <= NS; k++) begin
         word_ff[k] <= word_in[k];
         rot_ff[k] <= rot_in[k];
         amask_ff[k] <= amask_in[k];
         acc_ff[k] <= acc_in[k];
         m_ff[k] <= m_in[k];
      end
   end

   always_comb begin
      rsp_point_x = '0;
      rsp_point_y = '0;
      rsp_point_z = '0;
      for (int i = 0; i < COORD_W; i++) begin
         if (i < MAX_ORDER) begin
            rsp_point_x[i] = word_ff[NS][3*i];
            rsp_point_y[i] = word_ff[NS][3*i+1];
            rsp_point_z[i] = word_ff[NS][3*i+2];
         end
      end
   end

   assign rsp_strobe = valid_ff[NS];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(NS + 1) rsp_strobe)
      else $error("Accepted request did not produce a result at the expected latency.");

   a_order_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (m_ff[NS] != '0 && int'(m_ff[NS]) <= MAX_ORDER))
      else $error("Effective order left its legal range in the pipeline.");

   a_rot_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rot_ff[NS] != 2'd3)
      else $error("Rotation recurrence produced an illegal rotation.");

   a_high_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_point_x >> m_ff[NS]) == '0 && (rsp_point_y >> m_ff[NS]) == '0
                      && (rsp_point_z >> m_ff[NS]) == '0))
      else $error("Coordinate bits above the effective order are not zero.");

endmodule
